[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, status codes and word types of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int ARENA_BYTES = 4096;

    localparam int AW = $clog2(ARENA_BYTES);  // header store address
    localparam int HW = AW + 2;               // signed header
    localparam int PW = AW + 1;               // walk position, holds ARENA_BYTES
    localparam int SW = AW + 2;               // position plus block size

    localparam int REQ_W = 13;
    localparam int OFS_W = 12;
    localparam int ST_W  = 3;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_SIZE    = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_SPACE    = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_OFFSET  = 3'd3;
    localparam logic [ST_W-1:0] ST_DOUBLE_FREE = 3'd4;

    typedef struct packed {
        logic             mode;
        logic [REQ_W-1:0] req_size;
        logic [OFS_W-1:0] block_offset;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OFS_W-1:0] data_offset;
    } t_out_word;

endpackage

[rtl/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator over a byte arena of block headers.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ARENA_BYTES (4096)
// header store entries with in_ready low. It then takes one request word at
// a time. An allocate walks the block headers from offset 0 and may split the
// chosen block; a bad size is answered without a walk. A free merges the freed
// block with a free block after it and walks the blocks before it to merge a
// free one just before; an offset outside the arena is answered without a
// read, and an offset with no live header or a double free once its header is
// read. The walk speed is set by the header store's single read port: the walk
// reads one header per cycle, and the next address is formed from the header
// just read. The result goes to an output register and the next request can
// be taken while it waits there.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffha_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffha_pkg::t_out_word o_out_word
);

    localparam int AW = ffha_pkg::AW;
    localparam int HW = ffha_pkg::HW;
    localparam int PW = ffha_pkg::PW;
    localparam int SW = ffha_pkg::SW;
    localparam int OFS_W = ffha_pkg::OFS_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ARD  = 4'd2;
    localparam logic [3:0] S_AEV  = 4'd3;
    localparam logic [3:0] S_ASPL = 4'd4;
    localparam logic [3:0] S_FRD  = 4'd5;
    localparam logic [3:0] S_FH   = 4'd6;
    localparam logic [3:0] S_FN   = 4'd7;
    localparam logic [3:0] S_PST  = 4'd8;
    localparam logic [3:0] S_PEV  = 4'd9;
    localparam logic [3:0] S_HOLD = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [PW-1:0]       r_cur, n_cur;
    logic [PW-1:0]       r_need, n_need;
    logic [AW-1:0]       r_start, n_start;
    logic [PW-1:0]       r_p, n_p;
    logic signed [HW-1:0] r_hs, n_hs;
    ffha_pkg::t_out_word r_res, n_res;
    logic                r_out_valid, n_out_valid;
    ffha_pkg::t_out_word r_out_word, n_out_word;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [HW-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic signed [HW-1:0] rd_data;

    logic                 rd_neg;
    logic [HW-1:0]        rd_mag;
    logic [SW-1:0]        a_next;
    logic [SW-1:0]        f_next;
    logic [SW-1:0]        p_next;
    logic [HW-1:0]        rem;
    logic                 fit;
    logic                 split;
    logic signed [HW-1:0] hs_sum;
    logic                 bad_size;
    logic                 bad_off;

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (ffha_pkg::ARENA_BYTES)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_neg = rd_data[HW-1];
    assign rd_mag = rd_neg ? HW'(-rd_data) : HW'(rd_data);
    assign a_next = SW'(r_cur) + SW'(rd_mag);
    assign f_next = SW'(r_start) + SW'(rd_mag);
    assign p_next = SW'(r_p) + SW'(rd_mag);
    assign rem    = rd_mag - HW'(r_need);
    assign fit    = rd_neg && (rd_mag >= HW'(r_need));
    assign split  = rem >= HW'(3);
    assign hs_sum = r_hs + rd_data;

    assign bad_size = (i_in_word.req_size == '0) ||
                      (32'(i_in_word.req_size) > 32'(ffha_pkg::ARENA_BYTES - 2));
    assign bad_off  = (i_in_word.block_offset < OFS_W'(2)) ||
                      ((32'(i_in_word.block_offset) - 32'd2) >=
                       32'(ffha_pkg::ARENA_BYTES));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_need      = r_need;
        n_start     = r_start;
        n_p         = r_p;
        n_hs        = r_hs;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        wr_en       = 1'b0;
        wr_addr     = r_start;
        wr_data     = r_hs;
        rd_en       = 1'b0;
        rd_addr     = r_start;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr == '0) ? HW'(-ffha_pkg::ARENA_BYTES) : '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(ffha_pkg::ARENA_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.data_offset = '0;
                    if (!i_in_word.mode) begin
                        if (bad_size) begin
                            n_res.status = ffha_pkg::ST_BAD_SIZE;
                            n_state      = S_HOLD;
                        end else begin
                            n_need  = PW'(i_in_word.req_size) + PW'(2);
                            n_cur   = '0;
                            n_state = S_ARD;
                        end
                    end else begin
                        if (bad_off) begin
                            n_res.status = ffha_pkg::ST_BAD_OFFSET;
                            n_state      = S_HOLD;
                        end else begin
                            n_start = AW'(i_in_word.block_offset - OFS_W'(2));
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_ARD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_cur);
                n_state = S_AEV;
            end
            S_AEV: begin
                if (rd_mag == '0) begin
                    n_res.status = ffha_pkg::ST_NO_SPACE;
                    n_state      = S_HOLD;
                end else if (fit) begin
                    wr_en = 1'b1;
                    if (split) begin
                        wr_addr = AW'(r_cur + r_need);
                        wr_data = -$signed(rem);
                        n_state = S_ASPL;
                    end else begin
                        wr_addr           = AW'(r_cur);
                        wr_data           = $signed(rd_mag);
                        n_res.status      = ffha_pkg::ST_OK;
                        n_res.data_offset = OFS_W'(r_cur + PW'(2));
                        n_state           = S_HOLD;
                    end
                end else if (a_next >= SW'(ffha_pkg::ARENA_BYTES)) begin
                    n_res.status = ffha_pkg::ST_NO_SPACE;
                    n_state      = S_HOLD;
                end else begin
                    n_cur   = PW'(a_next);
                    rd_en   = 1'b1;
                    rd_addr = AW'(a_next);
                end
            end
            S_ASPL: begin
                wr_en             = 1'b1;
                wr_addr           = AW'(r_cur);
                wr_data           = $signed(HW'(r_need));
                n_res.status      = ffha_pkg::ST_OK;
                n_res.data_offset = OFS_W'(r_cur + PW'(2));
                n_state           = S_HOLD;
            end
            S_FRD: begin
                rd_en   = 1'b1;
                rd_addr = r_start;
                n_state = S_FH;
            end
            S_FH: begin
                if (rd_data == '0) begin
                    n_res.status = ffha_pkg::ST_BAD_OFFSET;
                    n_state      = S_HOLD;
                end else if (rd_neg) begin
                    n_res.status = ffha_pkg::ST_DOUBLE_FREE;
                    n_state      = S_HOLD;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_start;
                    wr_data = -rd_data;
                    n_hs    = -rd_data;
                    if (f_next < SW'(ffha_pkg::ARENA_BYTES)) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(f_next);
                        n_state = S_FN;
                    end else begin
                        n_state = S_PST;
                    end
                end
            end
            S_FN: begin
                if (rd_neg) begin
                    wr_en   = 1'b1;
                    wr_addr = r_start;
                    wr_data = hs_sum;
                    n_hs    = hs_sum;
                end
                n_state = S_PST;
            end
            S_PST: begin
                n_p = '0;
                if (r_start == '0) begin
                    n_res.status = ffha_pkg::ST_OK;
                    n_state      = S_HOLD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_state = S_PEV;
                end
            end
            S_PEV: begin
                if (rd_mag == '0) begin
                    n_res.status = ffha_pkg::ST_OK;
                    n_state      = S_HOLD;
                end else if (p_next == SW'(r_start)) begin
                    if (rd_neg) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_p);
                        wr_data = hs_sum;
                    end
                    n_res.status = ffha_pkg::ST_OK;
                    n_state      = S_HOLD;
                end else if (p_next < SW'(r_start)) begin
                    n_p     = PW'(p_next);
                    rd_en   = 1'b1;
                    rd_addr = AW'(p_next);
                end else begin
                    n_res.status = ffha_pkg::ST_OK;
                    n_state      = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_need     <= n_need;
        r_start    <= n_start;
        r_p        <= n_p;
        r_hs       <= n_hs;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[rtl/ffha_ram.sv]
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the first-fit allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ffha_pkg::t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped before accept");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status <= ffha_pkg::ST_DOUBLE_FREE))
        else $error("status code out of range");

    a_err_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ffha_pkg::ST_OK)
        |-> (o_out_word.data_offset == '0))
        else $error("nonzero offset on error");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("ready during header clear");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (.*);
